// File: sv/sem_pkg.sv
// shared types and constants for the sobel edge magnitude block
// no dependencies

package sem_pkg;

  typedef logic [23:0] pixel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_ROOT,
    ST_OUT
  } state_t;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [10:0] WIDTH_RESET  = 11'd640;
  localparam logic [12:0] HEIGHT_RESET = 13'd480;
  localparam logic [7:0]  MAG_MAX      = 8'd255;

  // weighted difference of two pixel triples, weights 1 2 1
  function automatic logic signed [10:0] grad(input logic [7:0] a0, input logic [7:0] a1,
                                              input logic [7:0] a2, input logic [7:0] b0,
                                              input logic [7:0] b1, input logic [7:0] b2);
    logic signed [10:0] d0, d1, d2;
    d0 = $signed({3'b000, b0}) - $signed({3'b000, a0});
    d1 = $signed({3'b000, b1}) - $signed({3'b000, a1});
    d2 = $signed({3'b000, b2}) - $signed({3'b000, a2});
    return d0 + (d1 <<< 1) + d2;
  endfunction

endpackage

// File: sv/sem_in_if.sv
// input pixel channel of the sobel edge magnitude block
// no dependencies

interface sem_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, operation, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, operation, red_in, green_in, blue_in, output ready);
endinterface

// File: sv/sem_out_if.sv
// result channel of the sobel edge magnitude block
// no dependencies

interface sem_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_edge;
  logic [7:0] green_edge;
  logic [7:0] blue_edge;
  logic       frame_last;

  modport source (output valid, red_edge, green_edge, blue_edge, frame_last, input ready);
  modport sink   (input valid, red_edge, green_edge, blue_edge, frame_last, output ready);
endinterface

// File: sv/sobel_edge_magnitude_top.sv
// sobel edge magnitude: line memories, 3x3 window, iterative rounded root
// depends on sem_pkg, sem_in_if, sem_out_if
//
// usage
//   in_ch carries rgb pixels in raster order (operation pixel) or drain items
//   after the frame end; out_ch carries the edge magnitude of each pixel, the
//   last one of a frame flagged by frame_last. output pixel k leaves when input
//   item k + width + 1 has been taken, i.e. one row plus one pixel late.
//   cfg_ sets width (address 0) and height (address 4); a write restarts the
//   frame, line memories are kept.
// timing
//   one item at a time: a transfer that yields a result passes the memory
//   read, window update, sums, eight steps of the shared root unit and the
//   output load before it reaches the result register, and only then is the
//   next item taken; an item without result passes the read stage only. the
//   root loop sets the rate.
// reset and stall
//   rst_n clears counters, window and the output valid; registers return to
//   640 x 480. memories need no clearing. a stalled receiver holds the result
//   register; the next result waits in the root unit and no item is taken.

module sobel_edge_magnitude_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  sem_in_if.sink       in_ch,
  sem_out_if.source    out_ch,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import sem_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;
  localparam int TW = WW + 13;

  // configuration registers
  logic [10:0] width_r;
  logic [12:0] height_r;
  logic        cfg_wr;
  logic        cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WIDTH:  width_r  <= cfg_pwdata[10:0];
        REG_HEIGHT: height_r <= cfg_pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_WIDTH:  cfg_prdata = {21'd0, width_r};
      REG_HEIGHT: cfg_prdata = {19'd0, height_r};
      default:    cfg_prdata = 32'd0;
    endcase
  end

  // effective frame size and pixel count
  logic [WW-1:0] eff_w;
  logic [12:0]   eff_h;
  logic [TW-1:0] total_r;

  always_comb begin
    if (width_r == 11'd0) eff_w = WW'(1);
    else if ({21'd0, width_r} > 32'(MAX_WIDTH)) eff_w = WW'(MAX_WIDTH);
    else eff_w = WW'(width_r);
    eff_h = (height_r == 13'd0) ? 13'd1 : height_r;
  end

  always_ff @(posedge clk) begin
    total_r <= TW'(eff_w) * TW'(eff_h);
  end

  // control state, row counts one past the frame during the flush
  state_t        state_r, state_nxt;
  logic [CW-1:0] col_r;
  logic [13:0]   row_r;
  logic [TW-1:0] done_r;
  logic [WW-1:0] col_eff;
  logic [WW-1:0] col_inc;
  logic          past_end;
  logic          accept;
  logic          start;
  logic          emit;
  logic          last;
  logic          out_free;
  logic [7:0]    bit_r;

  assign col_eff  = ({1'b0, col_r} >= eff_w) ? eff_w - WW'(1) : {1'b0, col_r};
  assign col_inc  = col_eff + WW'(1);
  assign past_end = row_r >= {1'b0, eff_h};
  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept   = in_ch.valid & in_ch.ready;
  assign start    = accept & (past_end | (in_ch.operation == OP_PIXEL));
  assign emit     = (row_r >= 14'd2) | ((row_r == 14'd1) & (col_eff != WW'(0)));
  assign last     = emit & ((done_r + TW'(1)) >= total_r);
  assign out_free = ~out_ch.valid | out_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start) state_nxt = ST_READ;
      ST_READ: state_nxt = emit ? ST_SUM : ST_IDLE;
      ST_SUM:  state_nxt = ST_ROOT;
      ST_ROOT: if (bit_r[0]) state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // line memories, read at accept and written back in the read stage
  pixel_t          mem_a [MAX_WIDTH];
  pixel_t          mem_b [MAX_WIDTH];
  pixel_t          rd_a_r, rd_b_r;
  pixel_t          pix_r;
  logic   [CW-1:0] addr;

  assign addr = col_eff[CW-1:0];

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      rd_a_r <= mem_a[addr];
      rd_b_r <= mem_b[addr];
    end
    if (state_r == ST_READ) begin
      mem_a[addr] <= rd_b_r;
      mem_b[addr] <= pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) pix_r <= past_end ? 24'd0 : {in_ch.red_in, in_ch.green_in, in_ch.blue_in};
  end

  // window update
  pixel_t win_r   [9];
  pixel_t win_nxt [9];
  pixel_t calc_r  [9];
  pixel_t calc_nxt[9];
  pixel_t newcol  [3];
  logic   col_zero;

  assign col_zero  = (col_eff == WW'(0));
  assign newcol[0] = (row_r >= 14'd2) ? rd_a_r : 24'd0;
  assign newcol[1] = (row_r >= 14'd1) ? rd_b_r : 24'd0;
  assign newcol[2] = pix_r;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      calc_nxt[r*3]   = win_r[r*3+1];
      calc_nxt[r*3+1] = win_r[r*3+2];
      calc_nxt[r*3+2] = col_zero ? 24'd0 : newcol[r];
      win_nxt[r*3]    = col_zero ? 24'd0 : calc_nxt[r*3];
      win_nxt[r*3+1]  = col_zero ? 24'd0 : calc_nxt[r*3+1];
      win_nxt[r*3+2]  = newcol[r];
    end
  end

  // counters and window
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      col_r  <= '0;
      row_r  <= '0;
      done_r <= '0;
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else if (state_r == ST_READ) begin
      if (last) begin
        col_r  <= '0;
        row_r  <= '0;
        done_r <= '0;
        for (int i = 0; i < 9; i++) win_r[i] <= '0;
      end else begin
        for (int i = 0; i < 9; i++) win_r[i] <= win_nxt[i];
        if (emit) done_r <= done_r + TW'(1);
        if (col_inc >= eff_w) begin
          col_r <= '0;
          row_r <= row_r + 14'd1;
        end else begin
          col_r <= col_inc[CW-1:0];
        end
      end
    end
  end

  logic last_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_READ) begin
      for (int i = 0; i < 9; i++) calc_r[i] <= calc_nxt[i];
      last_r <= last;
    end
  end

  // gradient sums and squares per channel
  logic [20:0]        sq_r  [3];
  logic signed [10:0] gv    [3];
  logic signed [10:0] gh    [3];
  logic [21:0]        sq_sum[3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      gv[c] = grad(calc_r[0][c*8 +: 8], calc_r[1][c*8 +: 8], calc_r[2][c*8 +: 8],
                   calc_r[6][c*8 +: 8], calc_r[7][c*8 +: 8], calc_r[8][c*8 +: 8]);
      gh[c] = grad(calc_r[0][c*8 +: 8], calc_r[3][c*8 +: 8], calc_r[6][c*8 +: 8],
                   calc_r[2][c*8 +: 8], calc_r[5][c*8 +: 8], calc_r[8][c*8 +: 8]);
      sq_sum[c] = (22'(gv[c]) * 22'(gv[c])) + (22'(gh[c]) * 22'(gh[c]));
    end
  end

  // shared rounded root: largest n with n*(n-1) below the sum, one bit a step
  logic [7:0]  n_r  [3];
  logic [7:0]  k    [3];
  logic [15:0] prod [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      k[c]    = n_r[c] | bit_r;
      prod[c] = 16'(k[c]) * 16'(k[c] - 8'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SUM) begin
      for (int c = 0; c < 3; c++) begin
        sq_r[c] <= sq_sum[c][20:0];
        n_r[c]  <= 8'd0;
      end
      bit_r <= 8'h80;
    end else if (state_r == ST_ROOT) begin
      for (int c = 0; c < 3; c++) begin
        if ({5'd0, prod[c]} < sq_r[c]) n_r[c] <= k[c];
      end
      bit_r <= bit_r >> 1;
    end
  end

  // result register, blue in lane 0
  logic out_valid_r;
  logic load;

  assign load = (state_r == ST_OUT) & out_free;
  assign out_ch.valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (load) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ch.red_edge   <= (n_r[2] > MAG_MAX) ? MAG_MAX : n_r[2];
      out_ch.green_edge <= n_r[1];
      out_ch.blue_edge  <= n_r[0];
      out_ch.frame_last <= last_r;
    end
  end

endmodule
